>>> rtl/byte_histogram_top_n_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte histogram block.
// Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef BYTE_HISTOGRAM_TOP_N_MACROS_SVH
`define BYTE_HISTOGRAM_TOP_N_MACROS_SVH

`ifndef NO_ASSERTIONS
// Combinational condition checked at every clock edge outside reset.
`define BH_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Condition in one cycle implies a condition in the following cycle.
`define BH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BH_ASSERT(lbl, expr, msg)
`define BH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/bh_pkg.sv
// ----------------------------------------------------------------------------
// bh_pkg
// Constants and shared types of the byte histogram with top-N report.
// ----------------------------------------------------------------------------
package bh_pkg;

  localparam int TOP_COUNT   = 10;
  localparam int COUNT_BITS  = 24;
  localparam int NUM_SYMBOLS = 256;
  localparam int SYM_W       = 8;
  localparam int OCC_W       = 24;
  localparam int RANK_W      = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [SYM_W-1:0]      SYM_LAST   = SYM_W'(NUM_SYMBOLS - 1);
  localparam logic [RANK_W-1:0]     RANK_FINAL = RANK_W'(TOP_COUNT - 1);

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT
  } bh_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_en;
    logic rank_reset;
    logic scan_start;
    logic load_out;
    logic clear_all;
  } bh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_acc;
    logic pass_done;
    logic found;
    logic is_final;
    logic out_free;
  } bh_stat_t;

endpackage

>>> rtl/bh_ctrl.sv
// ----------------------------------------------------------------------------
// bh_ctrl
// Sequencer: counting, pipeline drain, ranking passes and report emission.
// ----------------------------------------------------------------------------
module bh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bh_pkg::bh_stat_t stat_i,
  output bh_pkg::bh_cmd_t  cmd_o
);
  import bh_pkg::*;

  bh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COUNT: begin
        if (stat_i.last_acc) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.pass_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat_i.found) begin
          state_d = ST_COUNT;
        end else if (stat_i.out_free) begin
          state_d = stat_i.is_final ? ST_COUNT : ST_SCAN;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_COUNT: begin
        cmd_o.accept_en = 1'b1;
      end
      ST_DRAIN: begin
        // The last item's count is written at the end of this cycle.
        cmd_o.rank_reset = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd_o = '0;
      end
      ST_EMIT: begin
        if (!stat_i.found) begin
          cmd_o.clear_all = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.clear_all  = stat_i.is_final;
          cmd_o.scan_start = !stat_i.is_final;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/bh_datapath.sv
// ----------------------------------------------------------------------------
// bh_datapath
// Count memory with read-modify-write and forwarding, ranking scan and
// output register.
// ----------------------------------------------------------------------------
`include "byte_histogram_top_n_macros.svh"

module bh_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bh_pkg::bh_cmd_t                 cmd_i,
  output bh_pkg::bh_stat_t                stat_o,
  input  logic                            in_valid_i,
  input  logic [bh_pkg::SYM_W-1:0]        in_sym_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bh_pkg::SYM_W-1:0]        out_sym_o,
  output logic [bh_pkg::OCC_W-1:0]        out_occ_o,
  output logic [bh_pkg::RANK_W-1:0]       out_rank_o,
  output logic                            out_final_o
);
  import bh_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_SYMBOLS];
  logic [COUNT_BITS-1:0] rd_q;
  logic [NUM_SYMBOLS-1:0] vld_q;

  logic                  accept;
  logic                  rd_en;
  logic [SYM_W-1:0]      rd_addr;

  // Update stage of the counting pipeline.
  logic                  s2_valid_q;
  logic [SYM_W-1:0]      s2_sym_q;
  logic [COUNT_BITS-1:0] s2_old, s2_new;

  // The write of the previous edge, for forwarding.
  logic                  wr_vld_q;
  logic [SYM_W-1:0]      wr_sym_q;
  logic [COUNT_BITS-1:0] wr_cnt_q;

  // Ranking scan.
  logic                  scan_run_q;
  logic [SYM_W-1:0]      scan_addr_q;
  logic                  sc_valid_q;
  logic [SYM_W-1:0]      sc_sym_q;
  logic [COUNT_BITS-1:0] sc_cnt;
  logic                  elig;
  logic                  have_best_q, more_q, first_q;
  logic [SYM_W-1:0]      best_sym_q, prev_sym_q;
  logic [COUNT_BITS-1:0] best_cnt_q, prev_cnt_q;
  logic [RANK_W-1:0]     rank_q;

  logic                  out_valid_q;
  logic                  out_free;

  assign accept  = in_valid_i && cmd_i.accept_en;
  assign rd_en   = accept || scan_run_q;
  assign rd_addr = scan_run_q ? scan_addr_q : in_sym_i;

  always_comb begin
    if (wr_vld_q && (wr_sym_q == s2_sym_q)) begin
      s2_old = wr_cnt_q;
    end else if (vld_q[s2_sym_q]) begin
      s2_old = rd_q;
    end else begin
      s2_old = '0;
    end
    s2_new = (s2_old == COUNT_MAX) ? s2_old : s2_old + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) mem[s2_sym_q] <= s2_new;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // A pair that follows the previous one in descending count, ascending symbol.
  assign sc_cnt = vld_q[sc_sym_q] ? rd_q : '0;
  assign elig   = (sc_cnt != '0) &&
                  (first_q || (sc_cnt < prev_cnt_q) ||
                   ((sc_cnt == prev_cnt_q) && (sc_sym_q > prev_sym_q)));

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      wr_vld_q    <= 1'b0;
      vld_q       <= '0;
      scan_run_q  <= 1'b0;
      scan_addr_q <= '0;
      sc_valid_q  <= 1'b0;
      have_best_q <= 1'b0;
      more_q      <= 1'b0;
      first_q     <= 1'b1;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      wr_vld_q   <= s2_valid_q;
      if (cmd_i.clear_all) begin
        vld_q <= '0;
      end else if (s2_valid_q) begin
        vld_q[s2_sym_q] <= 1'b1;
      end

      sc_valid_q <= scan_run_q;
      if (cmd_i.scan_start) begin
        scan_run_q  <= 1'b1;
        scan_addr_q <= '0;
      end else if (scan_run_q) begin
        scan_addr_q <= scan_addr_q + 1'b1;
        if (scan_addr_q == SYM_LAST) scan_run_q <= 1'b0;
      end

      if (cmd_i.scan_start) begin
        have_best_q <= 1'b0;
        more_q      <= 1'b0;
      end else if (sc_valid_q && elig) begin
        have_best_q <= 1'b1;
        more_q      <= more_q || have_best_q;
      end

      if (cmd_i.rank_reset) begin
        rank_q  <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.load_out) begin
        rank_q  <= rank_q + 1'b1;
        first_q <= 1'b0;
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s2_sym_q <= in_sym_i;
    wr_sym_q <= s2_sym_q;
    wr_cnt_q <= s2_new;
    sc_sym_q <= scan_addr_q;
    if (!cmd_i.scan_start && sc_valid_q && elig &&
        (!have_best_q || (sc_cnt > best_cnt_q))) begin
      best_sym_q <= sc_sym_q;
      best_cnt_q <= sc_cnt;
    end
    if (cmd_i.load_out) begin
      prev_sym_q  <= best_sym_q;
      prev_cnt_q  <= best_cnt_q;
      out_sym_o   <= best_sym_q;
      out_occ_o   <= OCC_W'(best_cnt_q);
      out_rank_o  <= rank_q;
      out_final_o <= (rank_q == RANK_FINAL) || !more_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.last_acc  = accept && in_last_i;
  assign stat_o.pass_done = sc_valid_q && (sc_sym_q == SYM_LAST);
  assign stat_o.found     = have_best_q;
  assign stat_o.is_final  = (rank_q == RANK_FINAL) || !more_q;
  assign stat_o.out_free  = out_free;

  `BH_ASSERT(a_no_scan_while_counting, !(scan_run_q && (accept || s2_valid_q)),
             "ranking scan overlaps the counting pipeline")
  `BH_ASSERT(a_load_only_when_free, !cmd_i.load_out || out_free,
             "output register loaded while it still holds an item")
  `BH_ASSERT_NEXT(a_pass_finds_best, sc_valid_q && (sc_sym_q == SYM_LAST), have_best_q,
                  "ranking pass ended without a candidate")
  `BH_ASSERT_NEXT(a_clear_empties, cmd_i.clear_all, vld_q == '0,
                  "counts not cleared after the report")

endmodule

>>> rtl/byte_histogram_top_n.sv
// ----------------------------------------------------------------------------
// byte_histogram_top_n
// Byte frequency histogram with a ranked top-N report.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the slave channel, one item per accepted beat, with tlast
//   marking the final byte of a stream. Each byte bumps a saturating counter
//   in a 256-entry count memory; a counting item is taken every cycle while
//   tready is high, as the read-modify-write is pipelined into a read stage
//   and an update stage with forwarding. After the tlast item, tready drops
//   for the report: one pass over the memory per result, 256 reads at one per
//   cycle, each pass followed by an emit step, and up to TOP_COUNT passes.
//   The first result is valid after the drain step, the first pass and its
//   emit step. Each result leaves on the master channel: symbol, count and
//   rank, with tlast on the final one. Only values that occurred are reported,
//   ties going to the lower byte value.
//   The output register lets the next pass run while a result waits; a stall
//   on the master side holds the block after that pass.
//   After the final result is loaded, all counts clear in the same cycle and the
//   next stream may start at once. Reset clears the counts the same way.
// ----------------------------------------------------------------------------
module byte_histogram_top_n (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [bh_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // [7:0] data_byte
  input  logic                              s_axis_tlast_i,  // last_byte
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] symbol, [31:8] occurrences, [35:32] rank, [39:36] zero
  output logic [bh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o   // final_entry
);
  import bh_pkg::*;

  bh_cmd_t           cmd;
  bh_stat_t          stat;
  logic [SYM_W-1:0]  out_sym;
  logic [OCC_W-1:0]  out_occ;
  logic [RANK_W-1:0] out_rank;

  bh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid_i),
    .in_sym_i    (s_axis_tdata_i[SYM_W-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_sym_o   (out_sym),
    .out_occ_o   (out_occ),
    .out_rank_o  (out_rank),
    .out_final_o (m_axis_tlast_o)
  );

  assign s_axis_tready_o = cmd.accept_en;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - SYM_W - OCC_W - RANK_W)'(0),
                            out_rank, out_occ, out_sym};

endmodule

>>> test/tb_byte_histogram_top_n.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_histogram_top_n
// Self-checking testbench for the byte histogram with top-N report.
// Byte streams go in on the slave channel. Each accepted item is counted by
// a tally in the testbench. On a tlast item the tally ranks the values,
// queues the expected report and clears itself. Every result on the master
// channel is compared field by field with the oldest queued entry. Idling
// on both sides and a long receiver hold-off put gaps into every phase of
// the block's work.
// ----------------------------------------------------------------------------
module tb_byte_histogram_top_n;
  import bh_pkg::*;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 1500;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [OCC_W-1:0]  occurrences;
    logic [RANK_W-1:0] rank;
    logic              final_entry;
  } rank_entry_t;

  typedef enum int {
    MIX_NARROW,
    MIX_FULL,
    MIX_SKEWED
  } byte_mix_e;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   m_tready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  logic                   rx_hold = 1'b0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     mismatches = 0;
  int                     cycle_count = 0;

  logic [COUNT_BITS-1:0]  byte_tally [NUM_SYMBOLS];
  rank_entry_t            pending_ranks [$];

  byte_histogram_top_n i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),  // [7:0] data_byte
    .s_axis_tlast_i  (s_tlast),  // last_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    // [7:0] symbol, [31:8] occurrences, [35:32] rank, [39:36] zero
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)   // final_entry
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Counts one byte and, on the last byte of a stream, ranks the values,
  // queues the report and clears the tally.
  task automatic tally_byte(input logic [SYM_W-1:0] value, input logic last);
    rank_entry_t           report [TOP_COUNT];
    logic                  picked [NUM_SYMBOLS];
    logic [COUNT_BITS-1:0] best_cnt;
    rank_entry_t           entry;
    int                    best;
    int                    produced;
    logic                  exhausted;
    if (byte_tally[value] != COUNT_MAX) byte_tally[value] = byte_tally[value] + 1'b1;
    if (last) begin
      for (int s = 0; s < NUM_SYMBOLS; s++) picked[s] = 1'b0;
      produced  = 0;
      exhausted = 1'b0;
      for (int r = 0; r < TOP_COUNT && !exhausted; r++) begin
        best     = -1;
        best_cnt = '0;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
          if (!picked[s] && byte_tally[s] > best_cnt) begin
            best     = s;
            best_cnt = byte_tally[s];
          end
        end
        if (best < 0) begin
          exhausted = 1'b1;
        end else begin
          picked[best]            = 1'b1;
          entry.symbol            = SYM_W'(best);
          entry.occurrences       = OCC_W'(best_cnt);
          entry.rank              = RANK_W'(r);
          entry.final_entry       = 1'b0;
          report[produced]        = entry;
          produced++;
        end
      end
      for (int i = 0; i < produced; i++) begin
        entry             = report[i];
        entry.final_entry = (i == produced - 1);
        pending_ranks.push_back(entry);
      end
      for (int s = 0; s < NUM_SYMBOLS; s++) byte_tally[s] = '0;
    end
  endtask

  function automatic int field_differs(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : rx_check
    rank_entry_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        if (pending_ranks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h last %0b",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = pending_ranks.pop_front();
          mismatches += field_differs("symbol", want.symbol, m_tdata[SYM_W-1:0]);
          mismatches += field_differs("occurrences", want.occurrences,
                                      m_tdata[SYM_W +: OCC_W]);
          mismatches += field_differs("rank", want.rank, m_tdata[SYM_W+OCC_W +: RANK_W]);
          mismatches += field_differs("final_entry", want.final_entry, m_tlast);
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_byte(input logic [SYM_W-1:0] value, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tally_byte(value, last);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  task automatic send_random_stream(input int len, input byte_mix_e mix);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] pick;
    base = SYM_W'($urandom_range(255));
    for (int i = 0; i < len; i++) begin
      case (mix)
        MIX_NARROW: pick = base + SYM_W'($urandom_range(3));
        MIX_FULL:   pick = SYM_W'($urandom_range(255));
        default:    pick = ($urandom_range(99) < 90) ? base : SYM_W'($urandom_range(255));
      endcase
      send_byte(pick, i == len - 1);
    end
  endtask

  // Streams of one byte at both ends of the value range.
  task automatic test_single_values();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  // Only two values occur, so the report is shorter than the top list.
  task automatic test_few_values();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    wait_drained();
  endtask

  // Twelve values, one counted twice and the rest tied: the report is cut
  // at the top count and the ties must come out lowest value first.
  task automatic test_top_cut();
    send_byte(8'hC7, 1'b0);
    for (int i = 11; i >= 0; i--) send_byte(8'hC0 + SYM_W'(i), i == 0);
    wait_drained();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // items, so the block holds its report and its input stalls.
  task automatic test_back_pressure();
    send_idle_pct = 16;
    recv_idle_pct = 61;
    fork
      hold_receiver(HOLD_CYCLES);
      begin
        send_random_stream(16, MIX_FULL);
        send_random_stream(6, MIX_NARROW);
      end
    join
    wait_drained();
  endtask

  // One value dominates a long stream, so its count passes eight bits.
  task automatic test_deep_count();
    for (int i = 0; i < 265; i++) begin
      send_byte((i % 50 == 7) ? SYM_W'(i) : 8'h3C, i == 264);
    end
    wait_drained();
  endtask

  task automatic test_random_streams(input int budget, input int tx_idle, input int rx_idle);
    int        sent;
    int        len;
    byte_mix_e mix;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      mix = byte_mix_e'($urandom_range(2));
      send_random_stream(len, mix);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    for (int s = 0; s < NUM_SYMBOLS; s++) byte_tally[s] = '0;
    send_idle_pct = 16;
    recv_idle_pct = 61;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_values();
    test_few_values();
    test_top_cut();
    test_back_pressure();
    test_deep_count();
    test_random_streams(12, 16, 61);
    test_random_streams(12, 61, 16);
    test_random_streams(12, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_ranks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> byte_histogram_top_n.f
+incdir+rtl
rtl/bh_pkg.sv
rtl/bh_ctrl.sv
rtl/bh_datapath.sv
rtl/byte_histogram_top_n.sv
test/tb_byte_histogram_top_n.sv
